>>> hdl/gdr_pkg.sv
// Shared types and constants of the depth-first reachability block.
`default_nettype none

package gdr_pkg;

   // Item modes carried on the request tuser.
   localparam logic [1:0] MODE_CLEAR_ALL   = 2'd0;
   localparam logic [1:0] MODE_ADD_EDGE    = 2'd1;
   localparam logic [1:0] MODE_SEARCH      = 2'd2;
   localparam logic [1:0] MODE_CLEAR_MARKS = 2'd3;

   localparam int NODE_W   = 7;
   localparam int MASK_W   = 64;
   localparam int REQ_W    = 16;
   localparam int RSP_W    = 72;

   // Result word layout.
   localparam int RSP_COUNT_LO = 64;
   localparam int RSP_COUNT_HI = 70;
   localparam int RSP_ERR_BIT  = 71;

   typedef enum logic [9:0] {
      ST_IDLE      = 10'b00_0000_0001,
      ST_EDGE_RDA  = 10'b00_0000_0010,
      ST_EDGE_WRA  = 10'b00_0000_0100,
      ST_EDGE_RDB  = 10'b00_0000_1000,
      ST_EDGE_WRB  = 10'b00_0001_0000,
      ST_SRCH_POP  = 10'b00_0010_0000,
      ST_SRCH_ROW  = 10'b00_0100_0000,
      ST_SRCH_SCAN = 10'b00_1000_0000,
      ST_SRCH_PUSH = 10'b01_0000_0000,
      ST_DONE      = 10'b10_0000_0000
   } state_type;

endpackage

`default_nettype wire

>>> hdl/graph_dfs_reachability.sv
// Top level: graph store, visited marks and depth-first search sequencer.
//
// Usage. The req channel carries one command word per handshake: req_tuser
// holds the mode (clear all, add edge, search, clear marks) and req_tdata the
// two node numbers. Every command word yields exactly one rsp word with the
// visited mask after the command, the count of nodes newly reached by a
// search and a range error flag (the command is then ignored).
// csr_we/csr_wdata write node_count; write it only while no command is open.
// From one accepted command word to the next with the receiver ready:
// clear, clear marks, range errors and a search from a marked start go from
// idle straight to done, an edge insert through read and write of each row;
// the rsp word turns valid in the same cycle as the next accept can be taken.
// In a search each popped node costs a stack read, an adjacency row read, a
// scan step and a push-state step that finds no neighbor left, each pushed
// node a turn on the single stack write port.
// One command is worked on at a time; req_tready is high in idle, also while
// an earlier rsp word still waits to be taken.
// Reset clears the graph (per-row valid bits), the marks and node_count=64.
// When the receiver stalls, the finished result waits in the output register
// and the next command holds in its last cycle until the register frees.
`default_nettype none

module graph_dfs_reachability #(
   parameter int MAX_NODES = 64
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // csr: node_count
   input  wire logic                        csr_we,
   input  wire logic [gdr_pkg::NODE_W-1:0]  csr_wdata,
   // req_tdata: node_a [6:0], node_b [13:7], zero [15:14]
   input  wire logic                        req_tvalid,
   output      logic                        req_tready,
   input  wire logic [gdr_pkg::REQ_W-1:0]   req_tdata,
   // req_tuser: mode [1:0]
   input  wire logic [1:0]                  req_tuser,
   // rsp_tdata: visited_mask [63:0], newly_reached [70:64], range_error [71]
   output      logic                        rsp_tvalid,
   input  wire logic                        rsp_tready,
   output      logic [gdr_pkg::RSP_W-1:0]   rsp_tdata
);
   import gdr_pkg::*;

   localparam int IW = $clog2(MAX_NODES);
   localparam int CW = $clog2(MAX_NODES + 1);
   localparam logic [NODE_W-1:0] MAX_N = NODE_W'(MAX_NODES);

   // Control registers
   state_type          state_ff, state_in;
   logic [NODE_W-1:0]  node_count_ff;
   logic [MASK_W-1:0]  visited_ff, visited_in;
   logic [CW-1:0]      sp_ff, sp_in;
   logic [CW-1:0]      added_ff, added_in;
   logic               err_ff, err_in;
   logic [IW-1:0]      ia_ff, ia_in;
   logic [IW-1:0]      ib_ff, ib_in;
   logic [MASK_W-1:0]  fresh_ff, fresh_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]   rsp_data_ff, rsp_data_in;

   // Adjacency memory with per-row valid bits
   logic [MASK_W-1:0]  adj_mem_ff [MAX_NODES];
   logic [MAX_NODES-1:0] adj_vld_ff, adj_vld_in;
   logic [MASK_W-1:0]  adj_rdata_ff;
   logic               adj_rvld_ff;
   logic               adj_we;
   logic [IW-1:0]      adj_waddr, adj_raddr;
   logic [MASK_W-1:0]  adj_wdata;
   logic [MASK_W-1:0]  adj_row;
   logic               adj_clear;

   // Search stack memory
   logic [IW-1:0]      stk_mem_ff [MAX_NODES];
   logic [IW-1:0]      stk_rdata_ff;
   logic               stk_we;
   logic [IW-1:0]      stk_waddr, stk_raddr, stk_wdata;

   // Request decode
   logic [1:0]         req_mode;
   logic [NODE_W-1:0]  node_a, node_b, a_m1, b_m1;
   logic [NODE_W-1:0]  cnt_eff;
   logic               a_ok, b_ok;
   logic [MASK_W-1:0]  allowed;
   logic [MASK_W-1:0]  low_bit;
   logic [IW-1:0]      low_idx;
   logic               accept;

   assign req_mode = req_tuser;
   assign node_a   = req_tdata[NODE_W-1:0];
   assign node_b   = req_tdata[2*NODE_W-1:NODE_W];
   assign a_m1     = node_a - NODE_W'(1);
   assign b_m1     = node_b - NODE_W'(1);
   assign cnt_eff  = (node_count_ff > MAX_N) ? MAX_N : node_count_ff;
   assign a_ok     = (node_a != '0) && (node_a <= cnt_eff);
   assign b_ok     = (node_b != '0) && (node_b <= cnt_eff);

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Nodes the search may step onto
   always_comb begin
      for (int k = 0; k < MASK_W; k++) begin
         allowed[k] = (NODE_W'(k) < cnt_eff);
      end
   end

   // Lowest pending neighbor of the row being expanded
   assign low_bit = fresh_ff & (~fresh_ff + MASK_W'(1));
   always_comb begin
      low_idx = '0;
      for (int k = MAX_NODES - 1; k >= 0; k--) begin
         if (fresh_ff[k]) begin
            low_idx = IW'(k);
         end
      end
   end

   // A row that was never written since the last clear reads as zero
   assign adj_row = adj_rvld_ff ? adj_rdata_ff : '0;

   always_comb begin
      state_in     = state_ff;
      visited_in   = visited_ff;
      sp_in        = sp_ff;
      added_in     = added_ff;
      err_in       = err_ff;
      ia_in        = ia_ff;
      ib_in        = ib_ff;
      fresh_in     = fresh_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      adj_we       = 1'b0;
      adj_waddr    = ia_ff;
      adj_wdata    = '0;
      adj_raddr    = ia_ff;
      adj_clear    = 1'b0;
      stk_we       = 1'b0;
      stk_waddr    = sp_ff[IW-1:0];
      stk_wdata    = low_idx;
      stk_raddr    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ia_in    = a_m1[IW-1:0];
               ib_in    = b_m1[IW-1:0];
               added_in = '0;
               err_in   = 1'b0;
               state_in = ST_DONE;
               case (req_mode)
                  MODE_CLEAR_ALL: begin
                     adj_clear  = 1'b1;
                     visited_in = '0;
                  end
                  MODE_ADD_EDGE: begin
                     if (a_ok && b_ok) begin
                        state_in = ST_EDGE_RDA;
                     end else begin
                        err_in = 1'b1;
                     end
                  end
                  MODE_SEARCH: begin
                     if (!a_ok) begin
                        err_in = 1'b1;
                     end else if (!visited_ff[a_m1[IW-1:0]]) begin
                        // mark the start and seed the stack with it
                        visited_in = visited_ff | (MASK_W'(1) << a_m1[IW-1:0]);
                        added_in   = CW'(1);
                        stk_we     = 1'b1;
                        stk_waddr  = '0;
                        stk_wdata  = a_m1[IW-1:0];
                        sp_in      = CW'(1);
                        state_in   = ST_SRCH_POP;
                     end
                  end
                  default: begin
                     visited_in = '0;
                  end
               endcase
            end
         end
         ST_EDGE_RDA: begin
            adj_raddr = ia_ff;
            state_in  = ST_EDGE_WRA;
         end
         ST_EDGE_WRA: begin
            adj_we    = 1'b1;
            adj_waddr = ia_ff;
            adj_wdata = adj_row | (MASK_W'(1) << ib_ff);
            state_in  = ST_EDGE_RDB;
         end
         ST_EDGE_RDB: begin
            // read issued after the first write, so a self-loop sees it
            adj_raddr = ib_ff;
            state_in  = ST_EDGE_WRB;
         end
         ST_EDGE_WRB: begin
            adj_we    = 1'b1;
            adj_waddr = ib_ff;
            adj_wdata = adj_row | (MASK_W'(1) << ia_ff);
            state_in  = ST_DONE;
         end
         ST_SRCH_POP: begin
            stk_raddr = IW'(sp_ff - CW'(1));
            sp_in     = sp_ff - CW'(1);
            state_in  = ST_SRCH_ROW;
         end
         ST_SRCH_ROW: begin
            adj_raddr = stk_rdata_ff;
            state_in  = ST_SRCH_SCAN;
         end
         ST_SRCH_SCAN: begin
            fresh_in = adj_row & allowed & ~visited_ff;
            state_in = ST_SRCH_PUSH;
         end
         ST_SRCH_PUSH: begin
            if (fresh_ff != '0) begin
               // push one neighbor a cycle, lowest first
               stk_we     = 1'b1;
               stk_waddr  = sp_ff[IW-1:0];
               stk_wdata  = low_idx;
               sp_in      = sp_ff + CW'(1);
               added_in   = added_ff + CW'(1);
               visited_in = visited_ff | low_bit;
               fresh_in   = fresh_ff & ~low_bit;
            end else if (sp_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SRCH_POP;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {err_ff, NODE_W'(added_ff), visited_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      adj_vld_in = adj_vld_ff;
      if (adj_clear) begin
         adj_vld_in = '0;
      end else if (adj_we) begin
         adj_vld_in[adj_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= NODE_W'(64);
         visited_ff    <= '0;
         sp_ff         <= '0;
         added_ff      <= '0;
         err_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         adj_vld_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         if (csr_we) begin
            node_count_ff <= csr_wdata;
         end
         visited_ff    <= visited_in;
         sp_ff         <= sp_in;
         added_ff      <= added_in;
         err_ff        <= err_in;
         rsp_valid_ff  <= rsp_valid_in;
         adj_vld_ff    <= adj_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      ia_ff       <= ia_in;
      ib_ff       <= ib_in;
      fresh_ff    <= fresh_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Adjacency memory: one write and one read port, registered read
   always_ff @(posedge clock) begin
      if (adj_we) begin
         adj_mem_ff[adj_waddr] <= adj_wdata;
      end
      adj_rdata_ff <= adj_mem_ff[adj_raddr];
      adj_rvld_ff  <= adj_vld_in[adj_raddr];
   end

   // Stack memory: one write and one read port, registered read
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem_ff[stk_waddr] <= stk_wdata;
      end
      stk_rdata_ff <= stk_mem_ff[stk_raddr];
   end

endmodule

`default_nettype wire

>>> hdl/gdr_checker.sv
// Port-level checker for the reachability block and its bind.
`default_nettype none

module gdr_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       rsp_tvalid,
   input wire logic                       rsp_tready,
   input wire logic [gdr_pkg::RSP_W-1:0]  rsp_tdata
);
   import gdr_pkg::*;

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word dropped or changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   a_err_no_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_ERR_BIT] |->
         rsp_tdata[RSP_COUNT_HI:RSP_COUNT_LO] == '0)
      else $error("rejected command reports reached nodes");

   a_count_le_marks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         $countones(rsp_tdata[MASK_W-1:0]) >= int'(rsp_tdata[RSP_COUNT_HI:RSP_COUNT_LO]))
      else $error("newly reached count exceeds marked nodes");

endmodule

bind graph_dfs_reachability gdr_checker u_gdr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
